// ----- hw/rtl/wtg_pkg.sv -----
package wtg_pkg;

  // Field widths
  localparam int DIST_W = 16;
  localparam int MS_W   = 16;
  localparam int REG_W  = 16;
  localparam int ADDR_W = 3;

  // Stream packing
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 48;

  // Register indexes
  localparam logic [ADDR_W-1:0] REG_START_DIST  = 3'd0;
  localparam logic [ADDR_W-1:0] REG_END_DIST    = 3'd1;
  localparam logic [ADDR_W-1:0] REG_SAMPLE_PER  = 3'd2;
  localparam logic [ADDR_W-1:0] REG_METRO_PER   = 3'd3;
  localparam logic [ADDR_W-1:0] REG_TIMEOUT     = 3'd4;

  // Register reset values
  localparam logic [REG_W-1:0] START_DIST_RST = 16'd100;
  localparam logic [REG_W-1:0] END_DIST_RST   = 16'd350;
  localparam logic [REG_W-1:0] SAMPLE_PER_RST = 16'd20;
  localparam logic [REG_W-1:0] METRO_PER_RST  = 16'd500;
  localparam logic [REG_W-1:0] TIMEOUT_RST    = 16'd60000;

  // Zone margins in cm
  localparam logic [DIST_W:0] START_WIN   = 17'd3;
  localparam logic [DIST_W:0] RANGE_MARG  = 17'd20;
  localparam logic [DIST_W:0] END_WIN     = 17'd5;
  localparam logic [DIST_W:0] WALL_MARG   = 17'd50;
  localparam logic [DIST_W:0] METRO_MARG  = 17'd3;

  // Modes
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_MEAS = 2'd1;
  localparam logic [1:0] MODE_DONE = 2'd2;

  // Events
  localparam logic [2:0] EV_NONE   = 3'd0;
  localparam logic [2:0] EV_START  = 3'd1;
  localparam logic [2:0] EV_CANCEL = 3'd2;
  localparam logic [2:0] EV_DONE   = 3'd3;
  localparam logic [2:0] EV_WALL   = 3'd4;

  // Beeps
  localparam logic [1:0] BEEP_NONE  = 2'd0;
  localparam logic [1:0] BEEP_START = 2'd1;
  localparam logic [1:0] BEEP_METRO = 2'd2;
  localparam logic [1:0] BEEP_TUNE  = 2'd3;

  // Item kinds
  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef struct packed {
    logic [REG_W-1:0] start_distance;
    logic [REG_W-1:0] end_distance;
    logic [REG_W-1:0] sample_interval;
    logic [REG_W-1:0] metronome_period;
    logic [REG_W-1:0] timeout_limit;
  } cfg_t;

  typedef struct packed {
    logic              operation;
    logic [DIST_W-1:0] distance_cm;
    logic              button_pressed;
  } item_t;

  typedef struct packed {
    logic [1:0]      mode;
    logic            start_zone;
    logic            in_range;
    logic            end_zone;
    logic [2:0]      event_res;
    logic [1:0]      beep_request;
    logic            sample_request;
    logic [MS_W-1:0] elapsed_ms;
    logic [MS_W-1:0] walk_time_ms;
  } result_t;

endpackage

// ----- hw/rtl/walk_timing_gate.sv -----
// Channel | Direction | Handshake            | Payload
// in_     | slave     | in_tvalid/in_tready  | tdata: distance_cm, button_pressed; tuser: operation
// out_    | master    | out_tvalid/out_tready| tdata: mode .. walk_time_ms
// cfg_    | write     | cfg_we               | cfg_addr, cfg_wdata
//
// One item per clock sustained while out_tready stays high; each item passes through the input
// register, then one pass of compare/counter logic into the result register.
// Reset is synchronous on rst_n low: mode idle, timer and phases zero, registers default.
// A stalled out_tready holds the result register; the input register then fills and
// in_tready drops until the result transfer frees the slot.
module walk_timing_gate (
  input  logic                         clk,
  input  logic                         rst_n,
  // Input stream
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // [15:0] distance_cm, [16] button_pressed, [23:17] zero
  input  logic [wtg_pkg::IN_DATA_W-1:0]  in_tdata,
  // [0] operation
  input  logic                         in_tuser,
  // Result stream
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // [1:0] mode, [2] start_zone, [3] in_range, [4] end_zone, [7:5] event_res,
  // [9:8] beep_request, [10] sample_request, [26:11] elapsed_ms,
  // [42:27] walk_time_ms, [47:43] zero
  output logic [wtg_pkg::OUT_DATA_W-1:0] out_tdata,
  // Configuration writes
  input  logic                         cfg_we,
  input  logic [wtg_pkg::ADDR_W-1:0]     cfg_addr,
  input  logic [wtg_pkg::REG_W-1:0]      cfg_wdata
);
  import wtg_pkg::*;

  cfg_t    cfg;
  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    adv;
  result_t res;
  result_t out_res;

  // Unpack the incoming transfer
  assign in_item.operation      = in_tuser;
  assign in_item.distance_cm    = in_tdata[15:0];
  assign in_item.button_pressed = in_tdata[16];

  wtg_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  wtg_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_item    (in_item),
    .adv        (adv),
    .item_valid (item_valid),
    .item       (item)
  );

  // State and per-item logic; state commits only when the result register loads
  wtg_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .item  (item),
    .adv   (adv),
    .res   (res)
  );

  wtg_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .res        (res),
    .adv        (adv),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  // Pack the result, first field in the low bits
  assign out_tdata = {5'd0,
                      out_res.walk_time_ms,
                      out_res.elapsed_ms,
                      out_res.sample_request,
                      out_res.beep_request,
                      out_res.event_res,
                      out_res.end_zone,
                      out_res.in_range,
                      out_res.start_zone,
                      out_res.mode};

endmodule

// ----- hw/rtl/wtg_cfg_regs.sv -----
module wtg_cfg_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [wtg_pkg::ADDR_W-1:0] cfg_addr,
  input  logic [wtg_pkg::REG_W-1:0]  cfg_wdata,
  output wtg_pkg::cfg_t             cfg
);
  import wtg_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_distance   <= START_DIST_RST;
      cfg_r.end_distance     <= END_DIST_RST;
      cfg_r.sample_interval  <= SAMPLE_PER_RST;
      cfg_r.metronome_period <= METRO_PER_RST;
      cfg_r.timeout_limit    <= TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_START_DIST: cfg_r.start_distance   <= cfg_wdata;
        REG_END_DIST:   cfg_r.end_distance     <= cfg_wdata;
        REG_SAMPLE_PER: cfg_r.sample_interval  <= cfg_wdata;
        REG_METRO_PER:  cfg_r.metronome_period <= cfg_wdata;
        REG_TIMEOUT:    cfg_r.timeout_limit    <= cfg_wdata;
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- hw/rtl/wtg_in_stage.sv -----
module wtg_in_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  wtg_pkg::item_t in_item,
  input  logic          adv,
  output logic          item_valid,
  output wtg_pkg::item_t item
);
  import wtg_pkg::*;

  logic  valid_r;
  item_t item_r;

  // Take a new item when empty or when the held one moves on this cycle
  assign in_tready = !valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ----- hw/rtl/wtg_core.sv -----
module wtg_core (
  input  logic            clk,
  input  logic            rst_n,
  input  wtg_pkg::cfg_t   cfg,
  input  wtg_pkg::item_t  item,
  input  logic            adv,
  output wtg_pkg::result_t res
);
  import wtg_pkg::*;

  logic [1:0]        mode_r,      mode_nxt;
  logic              running_r,   running_nxt;
  logic [MS_W-1:0]   elapsed_r,   elapsed_nxt;
  logic [MS_W-1:0]   mphase_r,    mphase_nxt;
  logic [MS_W-1:0]   sphase_r,    sphase_nxt;
  logic [DIST_W-1:0] last_dist_r, last_dist_nxt;
  logic [MS_W-1:0]   walk_time_r, walk_time_nxt;

  always_comb begin
    logic [DIST_W:0] d, ld, s, e;
    logic [MS_W:0]   el_inc;
    logic [MS_W-1:0] sp_inc, mp_inc;
    logic            zs, zr, ze;
    logic [2:0]      ev;
    logic [1:0]      beep;
    logic            sreq;

    d  = {1'b0, item.distance_cm};
    ld = {1'b0, last_dist_r};
    s  = {1'b0, cfg.start_distance};
    e  = {1'b0, cfg.end_distance};
    el_inc = {1'b0, elapsed_r} + {{MS_W{1'b0}}, 1'b1};
    sp_inc = sphase_r + {{(MS_W-1){1'b0}}, 1'b1};
    mp_inc = mphase_r + {{(MS_W-1){1'b0}}, 1'b1};
    zs = 1'b0;
    zr = 1'b0;
    ze = 1'b0;
    ev = EV_NONE;
    beep = BEEP_NONE;
    sreq = 1'b0;

    mode_nxt      = mode_r;
    running_nxt   = running_r;
    elapsed_nxt   = elapsed_r;
    mphase_nxt    = mphase_r;
    sphase_nxt    = sphase_r;
    last_dist_nxt = last_dist_r;
    walk_time_nxt = walk_time_r;

    if (item.operation == OP_TICK) begin
      // Sample request pacing
      if (sp_inc >= cfg.sample_interval) begin
        sphase_nxt = '0;
        sreq = 1'b1;
      end else begin
        sphase_nxt = sp_inc;
      end
      if (running_r) begin
        // Wrap the timer at the limit or on 16-bit overflow
        if (el_inc >= {1'b0, cfg.timeout_limit} || el_inc[MS_W]) begin
          elapsed_nxt = '0;
          mphase_nxt  = '0;
        end else begin
          elapsed_nxt = el_inc[MS_W-1:0];
          mphase_nxt  = (mp_inc >= cfg.metronome_period) ? '0 : mp_inc;
        end
        if (mphase_nxt == '0 && ld < e + METRO_MARG && ld > s) begin
          beep = BEEP_METRO;
        end
      end
    end else begin
      last_dist_nxt = item.distance_cm;
      if ((mode_r == MODE_IDLE || mode_r == MODE_DONE) && item.button_pressed) begin
        mode_nxt = MODE_MEAS;
      end
      // Button held with the wall too near: abort back to idle
      if (item.button_pressed && d < e + WALL_MARG) begin
        mode_nxt    = MODE_IDLE;
        running_nxt = 1'b0;
        ev          = EV_WALL;
      end
      if (mode_nxt == MODE_MEAS) begin
        zs = (d > s) && (d < s + START_WIN);
        zr = (d < e + RANGE_MARG) && (d + RANGE_MARG > s);
        ze = (d > e) && (d < e + END_WIN);
        if (zs) begin
          elapsed_nxt = '0;
          mphase_nxt  = '0;
          running_nxt = 1'b1;
          ev          = EV_START;
          beep        = BEEP_START;
        end
        if (!zr && running_nxt) begin
          elapsed_nxt = '0;
          mphase_nxt  = '0;
          running_nxt = 1'b0;
          ev          = EV_CANCEL;
        end
        if (ze && running_nxt) begin
          walk_time_nxt = elapsed_nxt;
          elapsed_nxt   = '0;
          mphase_nxt    = '0;
          running_nxt   = 1'b0;
          mode_nxt      = MODE_DONE;
          ev            = EV_DONE;
          beep          = BEEP_TUNE;
        end
      end
    end

    res.mode           = mode_nxt;
    res.start_zone     = zs;
    res.in_range       = zr;
    res.end_zone       = ze;
    res.event_res      = ev;
    res.beep_request   = beep;
    res.sample_request = sreq;
    res.elapsed_ms     = elapsed_nxt;
    res.walk_time_ms   = walk_time_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      running_r   <= 1'b0;
      elapsed_r   <= '0;
      mphase_r    <= '0;
      sphase_r    <= '0;
      last_dist_r <= '0;
      walk_time_r <= '0;
    end else if (adv) begin
      mode_r      <= mode_nxt;
      running_r   <= running_nxt;
      elapsed_r   <= elapsed_nxt;
      mphase_r    <= mphase_nxt;
      sphase_r    <= sphase_nxt;
      last_dist_r <= last_dist_nxt;
      walk_time_r <= walk_time_nxt;
    end
  end

endmodule

// ----- hw/rtl/wtg_out_stage.sv -----
module wtg_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             item_valid,
  input  wtg_pkg::result_t res,
  output logic             adv,
  output logic             out_tvalid,
  input  logic             out_tready,
  output wtg_pkg::result_t out_res
);
  import wtg_pkg::*;

  logic    valid_r;
  result_t res_r;

  // Advance when an item waits and the result slot is free or draining
  assign adv = item_valid && (!valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_res    = res_r;

endmodule
